/* rtl/fixed_block_free_list_allocator_core_macros.svh */
// -----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core_macros.svh
// Assertion shorthands used by the allocator checker.
// -----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FBFL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbfl assertion failed");

// next-cycle implication, disabled while in reset
`define FBFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbfl assertion failed");

`endif

/* rtl/fbfl_pkg.sv */
// -----------------------------------------------------------------------------
// fbfl_pkg
// Types, constants and helpers for the fixed-block free-list allocator.
// -----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_SH    = $clog2(ALIGN_BYTES);
  localparam int SIZE_LIMIT  = 4096;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int SIZE_W = 13;
  localparam int OFF_W  = 22;
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_FREE_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE  = 2'd0,
    REG_BLOCK_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    req_type_e        req_type;
    logic [IDX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] block_index;
    logic [OFF_W-1:0] byte_offset;
    logic [CNT_W-1:0] in_use;
  } rsp_t;

  // link table access for one cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // clamp to [ALIGN_BYTES, SIZE_LIMIT], then round up to the alignment
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    s = raw;
    if (s > SIZE_W'(SIZE_LIMIT)) s = SIZE_W'(SIZE_LIMIT);
    if (s < SIZE_W'(ALIGN_BYTES)) s = SIZE_W'(ALIGN_BYTES);
    s = s + SIZE_W'(ALIGN_BYTES - 1);
    s[ALIGN_SH-1:0] = '0;
    return s;
  endfunction

  // zero acts as one, anything above the table depth as the depth
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
    logic [CNT_W-1:0] c;
    c = raw;
    if (c == '0) c = CNT_W'(1);
    if (c > CNT_W'(MAX_BLOCKS)) c = CNT_W'(MAX_BLOCKS);
    return c;
  endfunction

endpackage

/* rtl/fbfl_link_ram.sv */
// -----------------------------------------------------------------------------
// fbfl_link_ram
// Link table: one write and one registered read per cycle, write-first.
// -----------------------------------------------------------------------------
module fbfl_link_ram import fbfl_pkg::*; (
  input  logic             clk,
  input  ram_req_t         ram,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (ram.we) begin
      mem[ram.waddr] <= ram.wdata;
    end
  end

  // a push and the read of the new head hit the same entry
  always_ff @(posedge clk) begin
    if (ram.we && (ram.waddr == ram.raddr)) begin
      rd_data <= ram.wdata;
    end else begin
      rd_data <= mem[ram.raddr];
    end
  end

endmodule

/* rtl/fbfl_list_ctrl.sv */
// -----------------------------------------------------------------------------
// fbfl_list_ctrl
// Free-list head, use count, config registers and the table init sweep.
// Computes one response per accepted request.
// -----------------------------------------------------------------------------
module fbfl_list_ctrl import fbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 acc,
  input  req_t                 req,
  input  logic [IDX_W-1:0]     head_link,
  output ram_req_t             ram,
  output rsp_t                 result,
  output logic                 clearing
);

  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  used, used_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [SIZE_W-1:0] size, size_next;
  logic              clr_active, clr_active_next;
  logic [IDX_W-1:0]  clr_addr, clr_addr_next;
  logic [PROD_W-1:0] prod;

  assign prod     = PROD_W'(head) * PROD_W'(size);
  assign clearing = clr_active;

  always_comb begin
    head_next       = head;
    used_next       = used;
    cnt_next        = cnt;
    size_next       = size;
    clr_active_next = clr_active;
    clr_addr_next   = clr_addr;
    ram             = '0;
    result          = '0;
    result.status   = ST_OK;
    result.in_use   = used;

    if (clr_active) begin
      // entry i <- i-1, entry 0 <- 0
      ram.we        = 1'b1;
      ram.waddr     = clr_addr;
      ram.wdata     = (clr_addr == '0) ? '0 : clr_addr - IDX_W'(1);
      clr_addr_next = clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(MAX_BLOCKS - 1)) clr_active_next = 1'b0;
    end else if (acc) begin
      case (req.req_type)
        REQ_ALLOC: begin
          if (used >= cnt) begin
            result.status = ST_EXHAUSTED;
          end else begin
            result.block_index = head;
            result.byte_offset = prod[OFF_W-1:0];
            head_next          = head_link;
            used_next          = used + CNT_W'(1);
          end
        end
        REQ_FREE: begin
          if (used == '0) begin
            result.status = ST_FREE_EMPTY;
          end else begin
            ram.we    = 1'b1;
            ram.waddr = req.free_index;
            ram.wdata = head;
            head_next = req.free_index;
            used_next = used - CNT_W'(1);
          end
        end
        default: ;
      endcase
      result.in_use = used_next;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE: begin
          size_next = eff_size(cfg_data[SIZE_W-1:0]);
        end
        REG_BLOCK_COUNT: begin
          cnt_next        = eff_count(cfg_data[CNT_W-1:0]);
          head_next       = IDX_W'(cnt_next - CNT_W'(1));
          used_next       = '0;
          clr_active_next = 1'b1;
          clr_addr_next   = '0;
        end
        default: ;
      endcase
    end

    // keep the link of the head ready for the next cycle
    ram.raddr = head_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= IDX_W'(MAX_BLOCKS - 1);
      used       <= '0;
      cnt        <= CNT_W'(MAX_BLOCKS);
      size       <= SIZE_W'(ALIGN_BYTES);
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      head       <= head_next;
      used       <= used_next;
      cnt        <= cnt_next;
      size       <= size_next;
      clr_active <= clr_active_next;
      clr_addr   <= clr_addr_next;
    end
  end

endmodule

/* rtl/fbfl_out_buf.sv */
// -----------------------------------------------------------------------------
// fbfl_out_buf
// Two-entry response buffer; room is taken from registered fill only.
// -----------------------------------------------------------------------------
module fbfl_out_buf import fbfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t push_item,
  output logic has_room,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  rsp_t       slots [2];
  logic [1:0] fill, fill_next;
  logic       wr_ptr, rd_ptr;
  logic       pop;

  assign pop       = rsp_valid && rsp_ready;
  assign rsp_valid = (fill != 2'd0);
  assign has_room  = (fill != 2'd2);
  assign rsp       = slots[rd_ptr];
  assign fill_next = fill + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      fill <= fill_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
    end
  end

endmodule

/* rtl/fixed_block_free_list_allocator_core.sv */
// -----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Fixed-size block pool with a LIFO free list in a 1024-entry link table.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_t  (req_type, free_index)
//   rsp      out        rsp_valid / rsp_ready  rsp_t  (status, block_index,
//                                                      byte_offset, in_use)
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// One request per cycle while req_ready is high; its response is registered in the buffer.
// The link of the current head is held in the table's read register, so
// back-to-back allocates and frees need no extra cycles.
// After reset and after each write of the count register the table is
// initialized by a sweep over all 1024 entries, one entry a cycle; req_ready
// stays low meanwhile.
// A two-entry response buffer keeps requests flowing while a response stalls, until it is full.
// -----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core import fbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ram_req_t         ram;
  logic [IDX_W-1:0] head_link;
  rsp_t             result;
  logic             clearing;
  logic             has_room;
  logic             acc;

  assign req_ready = !clearing && has_room;
  assign acc       = req_valid && req_ready;

  fbfl_list_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .req       (req),
    .head_link (head_link),
    .ram       (ram),
    .result    (result),
    .clearing  (clearing)
  );

  fbfl_link_ram u_ram (
    .clk     (clk),
    .ram     (ram),
    .rd_data (head_link)
  );

  fbfl_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_item (result),
    .has_room  (has_room),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* rtl/fbfl_checker.sv */
// -----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks for the allocator, bound to the top level.
// -----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_core_macros.svh"

module fbfl_checker import fbfl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input rsp_t                 rsp,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  logic [1:0] pending;
  logic       acc_in, acc_out;
  logic       rsp_err, rsp_blank, count_wr;

  assign acc_in    = req_valid && req_ready;
  assign acc_out   = rsp_valid && rsp_ready;
  assign rsp_err   = rsp_valid && (rsp.status != ST_OK);
  assign rsp_blank = (rsp.block_index == '0) && (rsp.byte_offset == '0);
  assign count_wr  = cfg_we && (cfg_index == REG_BLOCK_COUNT);

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(acc_in) - 2'(acc_out);
    end
  end

  `FBFL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `FBFL_ASSERT_NOW(a_one_rsp_per_req, clk, rst, 1'b1, rsp_valid == (pending != 2'd0))
  `FBFL_ASSERT_NEXT(a_rebuild_blocks, clk, rst, count_wr, !req_ready)
  `FBFL_ASSERT_NOW(a_err_no_block, clk, rst, rsp_err, rsp_blank)

endmodule

bind fixed_block_free_list_allocator_core fbfl_checker u_fbfl_checker (.*);
